### rtl/core/complex_arith_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cau_pkg.sv
// Types, constants and widths shared by the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = PROD_W + 1;
  localparam int QBITS      = DATA_WIDTH + 1;
  localparam int PRE_SH     = DATA_WIDTH - FRAC_BITS;
  localparam int QDEPTH     = 2;
  localparam int PTR_W      = $clog2(QDEPTH);
  localparam int CNT_W      = $clog2(QDEPTH + 1);

  localparam logic [PROD_W-1:0] POS_LIM = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (DATA_WIDTH - 1);
  localparam logic [PROD_W-1:0] HALF    = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic [DATA_WIDTH-1:0] SAT_POS = POS_LIM[DATA_WIDTH-1:0];
  localparam logic [DATA_WIDTH-1:0] SAT_NEG = NEG_LIM[DATA_WIDTH-1:0];

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef logic signed [DATA_WIDTH-1:0] comp_t;

  typedef struct packed {
    op_t   op;
    logic  b_zero;
    comp_t a_re;
    comp_t a_im;
    comp_t b_re;
    comp_t b_im;
  } qent_t;

  typedef struct packed {
    logic              neg_re;
    logic              neg_im;
    logic              dovf_re;
    logic              dovf_im;
    logic              use_q;
    logic              dz;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [PROD_W-1:0] d;
    logic [QBITS-1:0]  low_re;
    logic [QBITS-1:0]  low_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
  } divst_t;
endpackage

### rtl/core/cau_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  comp_t      in_a_re,
  input  comp_t      in_a_im,
  input  comp_t      in_b_re,
  input  comp_t      in_b_im,
  output logic       q_valid,
  output qent_t      q_data,
  input  logic       q_pop
);
  qent_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  qent_t             ent;
  logic              push;

  assign in_ready = (cnt_r != CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    ent.op     = op_t'(in_req_type);
    ent.b_zero = (in_b_re == '0) && (in_b_im == '0);
    ent.a_re   = in_a_re;
    ent.a_im   = in_a_im;
    ent.b_re   = in_b_re;
    ent.b_im   = in_b_im;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end
endmodule

### rtl/core/cau_back.sv
// Back end: product, combine and pipelined-division stages with the output register.
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  qent_t q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output comp_t out_res_re,
  output comp_t out_res_im,
  output logic  out_overflowed,
  output logic  out_div_by_zero
);
  function automatic divst_t div_step(divst_t s);
    divst_t            r;
    logic [PROD_W:0]   t;
    logic              ge;
    r = s;
    if (s.use_q) begin
      t        = {s.mag_re, s.low_re[QBITS-1]};
      ge       = t >= {1'b0, s.d};
      t        = ge ? t - {1'b0, s.d} : t;
      r.mag_re = t[PROD_W-1:0];
      r.q_re   = {s.q_re[QBITS-2:0], ge};
      r.low_re = {s.low_re[QBITS-2:0], 1'b0};
      t        = {s.mag_im, s.low_im[QBITS-1]};
      ge       = t >= {1'b0, s.d};
      t        = ge ? t - {1'b0, s.d} : t;
      r.mag_im = t[PROD_W-1:0];
      r.q_im   = {s.q_im[QBITS-2:0], ge};
      r.low_im = {s.low_im[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [DATA_WIDTH:0] emit_part(logic neg, logic big,
                                                    logic [PROD_W-1:0] mag);
    logic [DATA_WIDTH-1:0] v;
    logic                  o;
    logic [PROD_W-1:0]     n;
    o = 1'b0;
    n = PROD_W'(0) - mag;
    if (neg) begin
      if (big || mag > NEG_LIM) begin
        v = SAT_NEG;
        o = 1'b1;
      end else begin
        v = n[DATA_WIDTH-1:0];
      end
    end else begin
      if (big || mag > POS_LIM) begin
        v = SAT_POS;
        o = 1'b1;
      end else begin
        v = mag[DATA_WIDTH-1:0];
      end
    end
    return {o, v};
  endfunction

  logic en;

  logic                     p_v_r;
  op_t                      p_op_r;
  logic                     p_dz_r;
  comp_t                    p_a_re_r, p_a_im_r, p_b_re_r, p_b_im_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_sr_r, p_si_r;

  logic                     c_v_r;
  op_t                      c_op_r;
  logic                     c_dz_r;
  logic signed [SUM_W-1:0]  c_sre_r, c_sim_r, c_sre_nxt, c_sim_nxt;
  logic [PROD_W-1:0]        c_d_r;

  divst_t                   st_r [QBITS+1];
  logic                     sv_r [QBITS+1];
  divst_t                   st0_nxt;

  logic                     out_valid_r;
  comp_t                    res_re_r, res_im_r;
  logic                     ovf_r, dz_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = q_valid && en;

  always_ff @(posedge clk) begin
    if (en) begin
      p_op_r   <= q_data.op;
      p_dz_r   <= q_data.b_zero;
      p_a_re_r <= q_data.a_re;
      p_a_im_r <= q_data.a_im;
      p_b_re_r <= q_data.b_re;
      p_b_im_r <= q_data.b_im;
      p_rr_r   <= q_data.a_re * q_data.b_re;
      p_ii_r   <= q_data.a_im * q_data.b_im;
      p_ir_r   <= q_data.a_im * q_data.b_re;
      p_ri_r   <= q_data.a_re * q_data.b_im;
      p_sr_r   <= q_data.b_re * q_data.b_re;
      p_si_r   <= q_data.b_im * q_data.b_im;
    end
  end

  always_comb begin
    case (p_op_r)
      OP_ADD: begin
        c_sre_nxt = SUM_W'(p_a_re_r) + SUM_W'(p_b_re_r);
        c_sim_nxt = SUM_W'(p_a_im_r) + SUM_W'(p_b_im_r);
      end
      OP_SUB: begin
        c_sre_nxt = SUM_W'(p_a_re_r) - SUM_W'(p_b_re_r);
        c_sim_nxt = SUM_W'(p_a_im_r) - SUM_W'(p_b_im_r);
      end
      OP_MUL: begin
        c_sre_nxt = SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
        c_sim_nxt = SUM_W'(p_ir_r) + SUM_W'(p_ri_r);
      end
      default: begin
        c_sre_nxt = SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
        c_sim_nxt = SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_op_r  <= p_op_r;
      c_dz_r  <= p_dz_r;
      c_sre_r <= c_sre_nxt;
      c_sim_r <= c_sim_nxt;
      c_d_r   <= $unsigned(p_sr_r) + $unsigned(p_si_r);
    end
  end

  always_comb begin
    logic [SUM_W-1:0]  abs_re, abs_im;
    logic [PROD_W-1:0] m_re, m_im;
    abs_re          = c_sre_r[SUM_W-1] ? -c_sre_r : c_sre_r;
    abs_im          = c_sim_r[SUM_W-1] ? -c_sim_r : c_sim_r;
    m_re            = abs_re[PROD_W-1:0];
    m_im            = abs_im[PROD_W-1:0];
    st0_nxt         = '0;
    st0_nxt.neg_re  = c_sre_r[SUM_W-1];
    st0_nxt.neg_im  = c_sim_r[SUM_W-1];
    st0_nxt.d       = c_d_r;
    st0_nxt.mag_re  = m_re;
    st0_nxt.mag_im  = m_im;
    case (c_op_r)
      OP_MUL: begin
        st0_nxt.mag_re = (m_re + HALF) >> FRAC_BITS;
        st0_nxt.mag_im = (m_im + HALF) >> FRAC_BITS;
      end
      OP_DIV: begin
        if (c_dz_r) begin
          st0_nxt.neg_re = 1'b0;
          st0_nxt.neg_im = 1'b0;
          st0_nxt.mag_re = '0;
          st0_nxt.mag_im = '0;
          st0_nxt.dz     = 1'b1;
        end else begin
          st0_nxt.use_q   = 1'b1;
          st0_nxt.dovf_re = {{PRE_SH{1'b0}}, m_re} >= {c_d_r, {PRE_SH{1'b0}}};
          st0_nxt.dovf_im = {{PRE_SH{1'b0}}, m_im} >= {c_d_r, {PRE_SH{1'b0}}};
          st0_nxt.mag_re  = m_re >> PRE_SH;
          st0_nxt.mag_im  = m_im >> PRE_SH;
          st0_nxt.low_re  = {m_re[PRE_SH-1:0], {(FRAC_BITS + 1){1'b0}}};
          st0_nxt.low_im  = {m_im[PRE_SH-1:0], {(FRAC_BITS + 1){1'b0}}};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= div_step(st_r[k]);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      sv_r[0]     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_v_r       <= q_pop;
      c_v_r       <= p_v_r;
      sv_r[0]     <= c_v_r;
      out_valid_r <= sv_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    logic [QBITS:0]        rq_re, rq_im;
    logic [PROD_W-1:0]     f_re, f_im;
    logic [DATA_WIDTH:0]   e_re, e_im;
    rq_re = ({1'b0, st_r[QBITS].q_re} + (QBITS + 1)'(1)) >> 1;
    rq_im = ({1'b0, st_r[QBITS].q_im} + (QBITS + 1)'(1)) >> 1;
    f_re  = st_r[QBITS].use_q ? PROD_W'(rq_re) : st_r[QBITS].mag_re;
    f_im  = st_r[QBITS].use_q ? PROD_W'(rq_im) : st_r[QBITS].mag_im;
    e_re  = emit_part(st_r[QBITS].neg_re, st_r[QBITS].use_q && st_r[QBITS].dovf_re, f_re);
    e_im  = emit_part(st_r[QBITS].neg_im, st_r[QBITS].use_q && st_r[QBITS].dovf_im, f_im);
    if (en) begin
      res_re_r <= comp_t'(e_re[DATA_WIDTH-1:0]);
      res_im_r <= comp_t'(e_im[DATA_WIDTH-1:0]);
      ovf_r    <= e_re[DATA_WIDTH] || e_im[DATA_WIDTH];
      dz_r     <= st_r[QBITS].dz;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = res_re_r;
  assign out_res_im      = res_im_r;
  assign out_overflowed  = ovf_r;
  assign out_div_by_zero = dz_r;
endmodule

### rtl/core/complex_arith_unit.sv
// Each item passes from the queue through the product, combine and divider stages to the output register.
// Throughput: one item per cycle while the output is not stalled; the 17-stage restoring divider is fully pipelined.
// A two-entry queue separates the front end from the back-end pipeline.
// Reset is synchronous and active low; it empties the queue and clears all valid bits.
`timescale 1ns / 1ps
`include "complex_arith_unit_defines.svh"
module complex_arith_unit import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  comp_t      in_a_re,
  input  comp_t      in_a_im,
  input  comp_t      in_b_re,
  input  comp_t      in_b_im,
  output logic       out_valid,
  input  logic       out_ready,
  output comp_t      out_res_re,
  output comp_t      out_res_im,
  output logic       out_overflowed,
  output logic       out_div_by_zero
);
  logic  q_valid;
  qent_t q_data;
  logic  q_pop;

  cau_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  cau_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res_re      (out_res_re),
    .out_res_im      (out_res_im),
    .out_overflowed  (out_overflowed),
    .out_div_by_zero (out_div_by_zero)
  );

  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_div_by_zero, out_res_re == '0 && out_res_im == '0 && !out_overflowed, "Divide by zero must give a zero result without overflow.")
  `CAU_ASSERT_IMP(a_ovf_sat, out_valid && out_overflowed, out_res_re == SAT_POS || out_res_re == SAT_NEG || out_res_im == SAT_POS || out_res_im == SAT_NEG, "Overflow flag set without a saturated part.")
  `CAU_ASSERT_NXT(a_rst_empty, !rst_n, !out_valid && in_ready, "Reset must empty the unit.")
endmodule

### tb/sv/cau_checker.sv
// Checker that watches both channels, predicts each complex result and compares it.
`timescale 1ns / 1ps
module cau_checker import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_req_type,
  input  comp_t      in_a_re,
  input  comp_t      in_a_im,
  input  comp_t      in_b_re,
  input  comp_t      in_b_im,
  input  logic       out_valid,
  input  logic       out_ready,
  input  comp_t      out_res_re,
  input  comp_t      out_res_im,
  input  logic       out_overflowed,
  input  logic       out_div_by_zero,
  output int         fail_count,
  output int         pending
);
  typedef struct packed {
    comp_t re;
    comp_t im;
    logic  ovf;
    logic  dz;
  } cplx_res_t;

  cplx_res_t result_q[$];

  function automatic longint unsigned quot_round(longint unsigned mag, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = mag / d;
    rem = mag % d;
    if (q > (64'd1 << (DATA_WIDTH - 1))) return (64'd1 << (DATA_WIDTH - 1)) + 1;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      q = q << 1;
      if (rem >= d - rem) begin
        rem = rem - (d - rem);
        q = q | 1;
      end else begin
        rem = rem << 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint sat_part(longint v, ref logic ovf);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    lo = -(64'sd1 <<< (DATA_WIDTH - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint round_q(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_part(longint n, longint unsigned d);
    longint unsigned m;
    longint q;
    m = (n < 0) ? -n : n;
    q = longint'(quot_round(m, d));
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_result(logic [1:0] op, comp_t ar, comp_t ai,
                                               comp_t br, comp_t bi);
    cplx_res_t r;
    longint re;
    longint im;
    longint unsigned d;
    logic ovf;
    ovf = 1'b0;
    r.dz = 1'b0;
    re = 0;
    im = 0;
    case (op_t'(op))
      OP_ADD: begin
        re = longint'(ar) + longint'(br);
        im = longint'(ai) + longint'(bi);
      end
      OP_SUB: begin
        re = longint'(ar) - longint'(br);
        im = longint'(ai) - longint'(bi);
      end
      OP_MUL: begin
        re = round_q(longint'(ar) * br - longint'(ai) * bi);
        im = round_q(longint'(ai) * br + longint'(ar) * bi);
      end
      default: begin
        d = longint'(br) * br + longint'(bi) * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          re = div_part(longint'(ar) * br + longint'(ai) * bi, d);
          im = div_part(longint'(ai) * br - longint'(ar) * bi, d);
        end
      end
    endcase
    r.re = comp_t'(sat_part(re, ovf));
    r.im = comp_t'(sat_part(im, ovf));
    r.ovf = ovf;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && in_valid && in_ready)
      result_q.push_back(complex_result(in_req_type, in_a_re, in_a_im, in_b_re, in_b_im));
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count = fail_count + 1;
      end else begin
        want = result_q.pop_front();
        if (out_res_re !== want.re) begin
          $error("res_re expected %0d actual %0d", want.re, out_res_re);
          fail_count = fail_count + 1;
        end
        if (out_res_im !== want.im) begin
          $error("res_im expected %0d actual %0d", want.im, out_res_im);
          fail_count = fail_count + 1;
        end
        if (out_overflowed !== want.ovf) begin
          $error("overflowed expected %0b actual %0b", want.ovf, out_overflowed);
          fail_count = fail_count + 1;
        end
        if (out_div_by_zero !== want.dz) begin
          $error("div_by_zero expected %0b actual %0b", want.dz, out_div_by_zero);
          fail_count = fail_count + 1;
        end
      end
    end
    pending = result_q.size();
  end
endmodule

### tb/sv/tb_top.sv
// Top level that drives random and directed complex operations into the unit.
`timescale 1ns / 1ps
module tb_top import cau_pkg::*;;
  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  comp_t      in_a_re;
  comp_t      in_a_im;
  comp_t      in_b_re;
  comp_t      in_b_im;
  logic       out_valid;
  logic       out_ready;
  comp_t      out_res_re;
  comp_t      out_res_im;
  logic       out_overflowed;
  logic       out_div_by_zero;
  int         fail_count;
  int         pending;

  complex_arith_unit DUT (.*);
  cau_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic comp_t pick_comp();
    case ($urandom_range(0, 9))
      0: return comp_t'(16'h8000);
      1: return comp_t'(16'h7fff);
      2: return comp_t'(0);
      3: return comp_t'($urandom_range(0, 1023)) - comp_t'(512);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic send_op(op_t op, comp_t ar, comp_t ai, comp_t br, comp_t bi);
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= op;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_in();
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    comp_t b_re;
    comp_t b_im;
    op_t   op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = OP_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_op(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0001);
    send_op(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000);
    send_op(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, 16'sh8000);
    send_op(OP_SUB, 16'sh1234, -16'sh0100, 16'sh0234, 16'sh0100);
    send_op(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_op(OP_MUL, 16'sh0180, 16'sh0000, 16'sh0001, 16'sh0000);
    send_op(OP_MUL, -16'sh0180, 16'sh0000, 16'sh0001, 16'sh0000);
    send_op(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_op(OP_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
    send_op(OP_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
    send_op(OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000);
    send_op(OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_op(OP_DIV, 16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000);
    send_op(OP_DIV, -16'sh0080, 16'sh0000, 16'sh0100, 16'sh0000);
    send_op(OP_DIV, 16'sh0001, 16'sh0001, 16'sh7fff, 16'sh7fff);
    send_op(OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0001);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 1650; i++) begin
      op = op_t'($urandom_range(0, 3));
      b_re = pick_comp();
      b_im = pick_comp();
      if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
        b_re = '0;
        b_im = '0;
      end
      send_op(op, pick_comp(), pick_comp(), b_re, b_im);
      if ($urandom_range(0, 2) == 0) pause_in();
      if (i == 800) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[complex_arith_unit] OK");
    end else begin
      $display("[complex_arith_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[complex_arith_unit] ERROR");
    $finish;
  end
endmodule
